/* src/hprd_pkg.sv */
// ----------------------------------------------------------------------------
// hprd_pkg
// Types, constants and register codes shared by the heartbeat peak-rate
// detector and its channel interfaces.
// ----------------------------------------------------------------------------
package hprd_pkg;

   localparam int SAMPLE_BITS   = 14;
   localparam int TICK_BITS     = 32;
   localparam int BEAT_BITS     = 16;
   localparam int RATE_BITS     = 32;
   localparam int INTERVAL_BITS = 16;
   localparam int CSR_IDX_BITS  = 8;
   localparam int CSR_DATA_BITS = 16;

   // rate in hundredths of a bpm is this constant over the interval in ms
   localparam int unsigned CENTI_BPM_NUM = 6000000;
   localparam int NUM_BITS   = $clog2(CENTI_BPM_NUM + 1);
   localparam int STEP_BITS  = $clog2(NUM_BITS + 1);

   typedef logic [SAMPLE_BITS-1:0]   sample_type;
   typedef logic [TICK_BITS-1:0]     tick_type;
   typedef logic [BEAT_BITS-1:0]     beat_type;
   typedef logic [RATE_BITS-1:0]     rate_type;
   typedef logic [INTERVAL_BITS-1:0] interval_type;
   typedef logic [CSR_IDX_BITS-1:0]  csr_idx_type;
   typedef logic [CSR_DATA_BITS-1:0] csr_data_type;
   typedef logic [NUM_BITS-1:0]      quot_type;
   typedef logic [STEP_BITS-1:0]     step_type;

   localparam csr_idx_type CSR_THRESHOLD    = csr_idx_type'(0);
   localparam csr_idx_type CSR_MIN_INTERVAL = csr_idx_type'(1);

   localparam sample_type   THRESHOLD_RESET    = sample_type'(9830);
   localparam interval_type MIN_INTERVAL_RESET = interval_type'(200);

   localparam quot_type DIV_NUMERATOR = quot_type'(CENTI_BPM_NUM);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_DELIVER
   } state_type;

   // divider handshake between sequencer and divider unit
   typedef struct packed {
      logic     start;
      tick_type divisor;
   } div_req_type;

   typedef struct packed {
      logic     done;
      quot_type quotient;
   } div_rsp_type;

endpackage

/* src/hprd_req_if.sv */
// ----------------------------------------------------------------------------
// hprd_req_if
// Sample channel: one sensor sample word per millisecond tick.
// ----------------------------------------------------------------------------
interface hprd_req_if import hprd_pkg::*; ();
   logic       valid;
   logic       ready;
   sample_type sample;

   modport source (output valid, output sample, input ready);
   modport sink   (input valid, input sample, output ready);
endinterface

/* src/hprd_rsp_if.sv */
// ----------------------------------------------------------------------------
// hprd_rsp_if
// Beat report channel: time, running count and rate of each detected beat.
// ----------------------------------------------------------------------------
interface hprd_rsp_if import hprd_pkg::*; ();
   logic     valid;
   logic     ready;
   tick_type beat_time;
   beat_type beat_number;
   rate_type rate_centi_bpm;

   modport source (output valid, output beat_time, output beat_number,
                   output rate_centi_bpm, input ready);
   modport sink   (input valid, input beat_time, input beat_number,
                   input rate_centi_bpm, output ready);
endinterface

/* src/hprd_csr_if.sv */
// ----------------------------------------------------------------------------
// hprd_csr_if
// Register write channel: register index and write data.
// ----------------------------------------------------------------------------
interface hprd_csr_if import hprd_pkg::*; ();
   logic         valid;
   logic         ready;
   csr_idx_type  index;
   csr_data_type data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

/* src/hprd_div.sv */
// ----------------------------------------------------------------------------
// hprd_div
// Restoring divider, one quotient bit per cycle: fixed rate numerator over a
// 32-bit tick interval.
// ----------------------------------------------------------------------------
module hprd_div import hprd_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  div_req_type div_req,
   output div_rsp_type div_rsp
);

   logic     busy_ff, busy_in;
   logic     done_ff, done_in;
   step_type step_ff, step_in;
   tick_type rem_ff, rem_in;
   tick_type divisor_ff, divisor_in;
   quot_type num_ff, num_in;
   quot_type quo_ff, quo_in;

   logic [TICK_BITS:0] trial;
   logic               fits;

   assign trial = {rem_ff, num_ff[NUM_BITS-1]};
   assign fits  = (trial >= {1'b0, divisor_ff});

   always_comb begin
      busy_in    = busy_ff;
      done_in    = 1'b0;
      step_in    = step_ff;
      rem_in     = rem_ff;
      divisor_in = divisor_ff;
      num_in     = num_ff;
      quo_in     = quo_ff;
      if (div_req.start) begin
         busy_in    = 1'b1;
         step_in    = step_type'(NUM_BITS);
         rem_in     = '0;
         divisor_in = div_req.divisor;
         num_in     = DIV_NUMERATOR;
         quo_in     = '0;
      end else if (busy_ff) begin
         // remainder stays below the divisor, so it fits the low bits
         if (fits) begin
            rem_in = TICK_BITS'(trial - {1'b0, divisor_ff});
         end else begin
            rem_in = trial[TICK_BITS-1:0];
         end
         num_in  = {num_ff[NUM_BITS-2:0], 1'b0};
         quo_in  = {quo_ff[NUM_BITS-2:0], fits};
         step_in = step_ff - step_type'(1);
         if (step_ff == step_type'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      rem_ff     <= rem_in;
      divisor_ff <= divisor_in;
      num_ff     <= num_in;
      quo_ff     <= quo_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;

endmodule

/* src/heartbeat_peak_rate_detector.sv */
// ----------------------------------------------------------------------------
// heartbeat_peak_rate_detector
// Local-maximum beat detector over a sample stream with interval-based rate.
// ----------------------------------------------------------------------------
// Usage:
//   req_ch carries one sample word per millisecond tick. Each accepted word
//   advances a 32-bit tick counter and judges the middle of the last three
//   samples. csr_ch writes threshold (index 0) and min_interval_ms (index 1);
//   it is always ready, other indexes are dropped. Write only while idle.
//   rsp_ch carries one word per detected beat: tick time, beat count and
//   rate in hundredths of a bpm.
// Timing:
//   a sample that gives no beat leaves the block idle; the next sample is taken in
//   the following cycle. A beat runs the divider, one quotient bit per cycle
//   over 23 bits, then the deliver step loads the beat word into the output
//   register; req_ch is not ready meanwhile.
//   The report sits in an output register; a new sample is accepted while it
//   waits. If the receiver still stalls when the next beat is ready, the
//   block holds in the deliver step and accepts no sample until it drains.
// Reset:
//   synchronous; registers return to threshold 9830, min interval 200,
//   armed, counters and sample history zero, no report pending.
// ----------------------------------------------------------------------------
module heartbeat_peak_rate_detector import hprd_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   hprd_req_if.sink    req_ch,
   hprd_rsp_if.source  rsp_ch,
   hprd_csr_if.sink    csr_ch
);

   state_type state_ff, state_in;

   sample_type   threshold_ff;
   interval_type min_interval_ff;
   sample_type   middle_ff, oldest_ff;
   logic         armed_ff, armed_in;
   tick_type     tick_ff;
   tick_type     last_beat_ff, last_beat_in;
   beat_type     beats_ff, beats_in;

   tick_type     pend_time_ff;
   beat_type     pend_number_ff;

   logic         rsp_valid_ff, rsp_valid_in;
   tick_type     rsp_time_ff;
   beat_type     rsp_number_ff;
   rate_type     rsp_rate_ff;

   div_req_type  div_req;
   div_rsp_type  div_rsp;

   logic         accept;
   logic         load_rsp;
   logic         is_peak;
   logic         beat;
   tick_type     tick_next;
   tick_type     interval;

   hprd_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff    <= THRESHOLD_RESET;
         min_interval_ff <= MIN_INTERVAL_RESET;
      end else if (csr_ch.valid) begin
         unique case (csr_ch.index)
            CSR_THRESHOLD:    threshold_ff    <= csr_ch.data[SAMPLE_BITS-1:0];
            CSR_MIN_INTERVAL: min_interval_ff <= csr_ch.data[INTERVAL_BITS-1:0];
            default: ;
         endcase
      end
   end

   // detection on the middle sample of the three most recent
   assign tick_next = tick_ff + tick_type'(1);
   assign interval  = tick_next - last_beat_ff;
   assign is_peak   = (middle_ff > threshold_ff) && (middle_ff >= req_ch.sample)
                      && (middle_ff >= oldest_ff);
   assign beat      = armed_ff && is_peak
                      && (interval > TICK_BITS'(min_interval_ff));

   always_comb begin
      state_in        = state_ff;
      req_ch.ready    = 1'b0;
      div_req.start   = 1'b0;
      div_req.divisor = interval;
      load_rsp        = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ch.ready = 1'b1;
            if (req_ch.valid && beat) begin
               div_req.start = 1'b1;
               state_in      = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            if (div_rsp.done) begin
               state_in = ST_DELIVER;
            end
         end
         ST_DELIVER: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               load_rsp = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign accept = req_ch.valid && req_ch.ready;

   always_comb begin
      armed_in     = armed_ff;
      last_beat_in = last_beat_ff;
      beats_in     = beats_ff;
      if (accept) begin
         if (beat) begin
            armed_in     = 1'b0;
            last_beat_in = tick_next;
            beats_in     = beats_ff + beat_type'(1);
         end else if (!armed_ff && (middle_ff < threshold_ff)) begin
            armed_in = 1'b1;
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         middle_ff    <= '0;
         oldest_ff    <= '0;
         armed_ff     <= 1'b1;
         tick_ff      <= '0;
         last_beat_ff <= '0;
         beats_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         armed_ff     <= armed_in;
         last_beat_ff <= last_beat_in;
         beats_ff     <= beats_in;
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            tick_ff   <= tick_next;
            oldest_ff <= middle_ff;
            middle_ff <= req_ch.sample;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept && beat) begin
         pend_time_ff   <= tick_next;
         pend_number_ff <= beats_ff + beat_type'(1);
      end
      if (load_rsp) begin
         rsp_time_ff   <= pend_time_ff;
         rsp_number_ff <= pend_number_ff;
         rsp_rate_ff   <= RATE_BITS'(div_rsp.quotient);
      end
   end

   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.beat_time      = rsp_time_ff;
   assign rsp_ch.beat_number    = rsp_number_ff;
   assign rsp_ch.rate_centi_bpm = rsp_rate_ff;

endmodule

/* sim/heartbeat_peak_rate_detector_tb.sv */
// ----------------------------------------------------------------------------
// heartbeat_peak_rate_detector_tb
// Drives sample words, register writes and receiver stalls into the beat
// detector. A short table covers the edge cases first, then pulse-shaped
// random traffic runs under several register settings. Every beat word is
// checked against a local model of the detector or a typed row's hand-worked beat.
// ----------------------------------------------------------------------------
module heartbeat_peak_rate_detector_tb;
   import hprd_pkg::*;

   localparam int HALF_PERIOD   = 4;
   localparam int SETTLE_CYCLES = 40;
   localparam int LIMIT_TIME    = 4_000_000;
   localparam sample_type  SAMPLE_MAX = '1;
   localparam csr_idx_type CSR_UNUSED = csr_idx_type'(8'hFE);

   typedef struct packed {
      tick_type at_tick;
      beat_type number;
      rate_type centi_bpm;
   } beat_rec_type;

   typedef enum logic {ROW_SMP, ROW_CSR} row_kind_type;

   typedef struct packed {
      row_kind_type kind;
      csr_idx_type  idx;
      csr_data_type value;
      logic         typed;
      tick_type     at_tick;
      beat_type     number;
      rate_type     centi_bpm;
   } dir_row_type;

   localparam beat_rec_type NO_BEAT = '0;

   logic clock = 1'b0;
   logic reset;

   hprd_req_if req_if ();
   hprd_rsp_if rsp_if ();
   hprd_csr_if csr_if ();

   heartbeat_peak_rate_detector i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_if),
      .rsp_ch (rsp_if),
      .csr_ch (csr_if)
   );

   // detector model state
   sample_type   thresh;
   interval_type min_gap;
   sample_type   mid_smp;
   sample_type   old_smp;
   bit           is_armed;
   tick_type     tick_now;
   tick_type     last_beat;
   beat_type     beat_total;

   beat_rec_type pending_beats[$];
   int unsigned  fails = 0;
   bit           no_stall = 1'b0;

   // edge cases; typed rows carry a beat worked out by hand
   dir_row_type dir_rows [24] = '{
      '{ROW_SMP, CSR_UNUSED, 16'd16383, 1'b0, 32'd0, 16'd0, 32'd0},
      // peak at tick 2 blocked by the reset min interval
      '{ROW_SMP, CSR_UNUSED, 16'd0, 1'b0, 32'd0, 16'd0, 32'd0},
      '{ROW_CSR, CSR_MIN_INTERVAL, 16'd0, 1'b0, 32'd0, 16'd0, 32'd0},
      '{ROW_SMP, CSR_UNUSED, 16'd0, 1'b0, 32'd0, 16'd0, 32'd0},
      '{ROW_SMP, CSR_UNUSED, 16'd9830, 1'b0, 32'd0, 16'd0, 32'd0},
      // middle equal to the reset threshold
      '{ROW_SMP, CSR_UNUSED, 16'd0, 1'b0, 32'd0, 16'd0, 32'd0},
      '{ROW_SMP, CSR_UNUSED, 16'd9831, 1'b0, 32'd0, 16'd0, 32'd0},
      // middle equal to newest still counts
      '{ROW_SMP, CSR_UNUSED, 16'd9831, 1'b1, 32'd7, 16'd1, 32'd857142},
      '{ROW_SMP, CSR_UNUSED, 16'd0, 1'b0, 32'd0, 16'd0, 32'd0},
      '{ROW_SMP, CSR_UNUSED, 16'd16383, 1'b0, 32'd0, 16'd0, 32'd0},
      '{ROW_SMP, CSR_UNUSED, 16'd0, 1'b1, 32'd10, 16'd2, 32'd2000000},
      '{ROW_SMP, CSR_UNUSED, 16'd16383, 1'b0, 32'd0, 16'd0, 32'd0},
      // shortest possible interval
      '{ROW_SMP, CSR_UNUSED, 16'd0, 1'b1, 32'd12, 16'd3, 32'd3000000},
      '{ROW_CSR, CSR_MIN_INTERVAL, 16'd3, 1'b0, 32'd0, 16'd0, 32'd0},
      '{ROW_SMP, CSR_UNUSED, 16'd14000, 1'b0, 32'd0, 16'd0, 32'd0},
      '{ROW_SMP, CSR_UNUSED, 16'd14000, 1'b0, 32'd0, 16'd0, 32'd0},
      // interval equal to the minimum
      '{ROW_SMP, CSR_UNUSED, 16'd13000, 1'b0, 32'd0, 16'd0, 32'd0},
      // older neighbor above the middle
      '{ROW_SMP, CSR_UNUSED, 16'd12000, 1'b0, 32'd0, 16'd0, 32'd0},
      '{ROW_SMP, CSR_UNUSED, 16'd16383, 1'b0, 32'd0, 16'd0, 32'd0},
      '{ROW_SMP, CSR_UNUSED, 16'd0, 1'b1, 32'd18, 16'd4, 32'd1000000},
      '{ROW_CSR, CSR_UNUSED, 16'd0, 1'b0, 32'd0, 16'd0, 32'd0},
      // upper data bits of the threshold are dropped
      '{ROW_CSR, CSR_THRESHOLD, 16'hC064, 1'b0, 32'd0, 16'd0, 32'd0},
      '{ROW_SMP, CSR_UNUSED, 16'd101, 1'b0, 32'd0, 16'd0, 32'd0},
      '{ROW_SMP, CSR_UNUSED, 16'd0, 1'b0, 32'd0, 16'd0, 32'd0}
   };

   always #HALF_PERIOD clock = ~clock;

   initial begin
      #LIMIT_TIME;
      $display("simulation failed");
      $finish;
   end

   function automatic bit predict_beat(input sample_type s, output beat_rec_type rec);
      tick_type span;
      bit       hit;
      hit = 1'b0;
      rec = NO_BEAT;
      tick_now = tick_now + 1;
      if (is_armed) begin
         if (mid_smp > thresh && mid_smp >= s && mid_smp >= old_smp) begin
            span = tick_now - last_beat;
            if (span > tick_type'(min_gap)) begin
               beat_total    = beat_total + 1;
               last_beat     = tick_now;
               is_armed      = 1'b0;
               rec.at_tick   = tick_now;
               rec.number    = beat_total;
               rec.centi_bpm = rate_type'(CENTI_BPM_NUM / span);
               hit = 1'b1;
            end
         end
      end else if (mid_smp < thresh) begin
         is_armed = 1'b1;
      end
      old_smp = mid_smp;
      mid_smp = s;
      return hit;
   endfunction

   function automatic sample_type below_level();
      return (thresh == '0) ? sample_type'(0) : sample_type'($urandom_range(thresh - 1));
   endfunction

   function automatic sample_type above_level();
      return (thresh == SAMPLE_MAX) ? SAMPLE_MAX :
             sample_type'($urandom_range(SAMPLE_MAX, thresh + 1));
   endfunction

   task automatic send_sample(input sample_type s, input bit typed,
                              input beat_rec_type typed_rec);
      beat_rec_type rec;
      @(negedge clock);
      while (!no_stall && $urandom_range(99) < 27) begin
         req_if.valid = 1'b0;
         @(negedge clock);
      end
      req_if.valid  = 1'b1;
      req_if.sample = s;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      if (predict_beat(s, rec) || typed)
         pending_beats.push_back(typed ? typed_rec : rec);
   endtask

   task automatic feed(input sample_type s);
      send_sample(s, 1'b0, NO_BEAT);
   endtask

   task automatic drain_beats();
      @(negedge clock);
      req_if.valid = 1'b0;
      while (pending_beats.size() != 0) @(posedge clock);
   endtask

   task automatic write_csr(input csr_idx_type idx, input csr_data_type data);
      drain_beats();
      // a sample word with no beat may still be in flight
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
      csr_if.valid = 1'b1;
      csr_if.index = idx;
      csr_if.data  = data;
      @(posedge clock);
      while (!csr_if.ready) @(posedge clock);
      if (idx == CSR_THRESHOLD)
         thresh = data[SAMPLE_BITS-1:0];
      else if (idx == CSR_MIN_INTERVAL)
         min_gap = data;
      @(negedge clock);
      csr_if.valid = 1'b0;
   endtask

   // pulses around the threshold, with some noise bursts and flat peaks
   task automatic send_wave(input int unsigned count);
      int unsigned left;
      int unsigned n_low;
      int unsigned n_rise;
      int unsigned n_top;
      int unsigned n_fall;
      sample_type  peak;
      left = count;
      while (left > 0) begin
         if ($urandom_range(9) == 0) begin
            n_low = $urandom_range(1, 5);
            repeat (n_low) feed(sample_type'($urandom));
            left = (left > n_low) ? left - n_low : 0;
         end else begin
            n_low  = $urandom_range(1, 4);
            n_rise = $urandom_range(0, 2);
            n_top  = $urandom_range(1, 2);
            n_fall = $urandom_range(1, 3);
            repeat (n_low) feed(below_level());
            peak = ($urandom_range(7) == 0) ? thresh : above_level();
            repeat (n_rise) feed(sample_type'($urandom_range(peak, thresh)));
            repeat (n_top) feed(peak);
            repeat (n_fall) feed(sample_type'($urandom_range(peak)));
            n_low = n_low + n_rise + n_top + n_fall;
            left  = (left > n_low) ? left - n_low : 0;
         end
      end
   endtask

   always @(negedge clock)
      rsp_if.ready = no_stall || ($urandom_range(99) >= 27);

   always @(posedge clock) begin : beat_check
      beat_rec_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (pending_beats.size() == 0) begin
            $display("%0t: beat word with none expected: time %0d number %0d rate %0d",
                     $time, rsp_if.beat_time, rsp_if.beat_number, rsp_if.rate_centi_bpm);
            fails++;
         end else begin
            want = pending_beats.pop_front();
            if (rsp_if.beat_time !== want.at_tick) begin
               $display("%0t: beat_time expected %0d got %0d",
                        $time, want.at_tick, rsp_if.beat_time);
               fails++;
            end
            if (rsp_if.beat_number !== want.number) begin
               $display("%0t: beat_number expected %0d got %0d",
                        $time, want.number, rsp_if.beat_number);
               fails++;
            end
            if (rsp_if.rate_centi_bpm !== want.centi_bpm) begin
               $display("%0t: rate_centi_bpm expected %0d got %0d",
                        $time, want.centi_bpm, rsp_if.rate_centi_bpm);
               fails++;
            end
         end
      end
   end

   initial begin
      int unsigned  n_items;
      csr_data_type thr_w;
      csr_data_type gap_w;
      reset         = 1'b1;
      req_if.valid  = 1'b0;
      req_if.sample = '0;
      csr_if.valid  = 1'b0;
      csr_if.index  = '0;
      csr_if.data   = '0;
      rsp_if.ready  = 1'b1;
      thresh     = THRESHOLD_RESET;
      min_gap    = MIN_INTERVAL_RESET;
      mid_smp    = '0;
      old_smp    = '0;
      is_armed   = 1'b1;
      tick_now   = '0;
      last_beat  = '0;
      beat_total = '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (dir_rows[i]) begin
         if (dir_rows[i].kind == ROW_CSR)
            write_csr(dir_rows[i].idx, dir_rows[i].value);
         else
            send_sample(sample_type'(dir_rows[i].value), dir_rows[i].typed,
                        beat_rec_type'{dir_rows[i].at_tick, dir_rows[i].number,
                                       dir_rows[i].centi_bpm});
      end

      for (int ph = 0; ph < 6; ph++) begin
         case (ph)
            0: begin
               thr_w = csr_data_type'(THRESHOLD_RESET);
               gap_w = 16'd4;
               n_items = 250;
            end
            1: begin
               thr_w = '0;
               gap_w = '0;
               n_items = 150;
            end
            2: begin
               thr_w = '1;
               gap_w = '1;
               n_items = 100;
            end
            3: begin
               thr_w = {2'($urandom), 14'($urandom_range(14000, 2000))};
               gap_w = 16'($urandom_range(20));
               n_items = 300;
            end
            4: begin
               thr_w = {2'($urandom), 14'($urandom_range(14000, 2000))};
               gap_w = MIN_INTERVAL_RESET;
               n_items = 300;
            end
            default: begin
               thr_w = {2'($urandom), 14'($urandom_range(14000, 2000))};
               gap_w = 16'($urandom_range(12));
               n_items = 350;
            end
         endcase
         no_stall = 1'b0;
         write_csr(CSR_THRESHOLD, thr_w);
         write_csr(CSR_MIN_INTERVAL, gap_w);
         // stray index, must not touch either register
         write_csr(csr_idx_type'($urandom_range(255, 2)), csr_data_type'($urandom));
         no_stall = (ph == 3);
         send_wave(n_items / 2);
         drain_beats();
         send_wave(n_items - n_items / 2);
      end

      no_stall = 1'b0;
      drain_beats();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fails == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule

/* sim.f */
src/hprd_pkg.sv
src/hprd_req_if.sv
src/hprd_rsp_if.sv
src/hprd_csr_if.sv
src/hprd_div.sv
src/heartbeat_peak_rate_detector.sv
sim/heartbeat_peak_rate_detector_tb.sv
